[rtl/core/uer_pkg.sv]
// Shared types and constants for the ultrasonic echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

  // Field and register widths
  localparam int TRIG_W    = 20;
  localparam int WIN_W     = 22;
  localparam int TIMEOUT_W = 18;
  localparam int TIMER_W   = 22;
  localparam int COUNT_W   = 18;
  localparam int DIST_W    = 16;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;

  // Register reset values
  localparam logic [TRIG_W-1:0]    TRIG_RST    = TRIG_W'(90000);
  localparam logic [WIN_W-1:0]     WIN_RST     = WIN_W'(300000);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(180000);

  // Register indexes (word address bits)
  localparam logic [1:0] REG_TRIGGER = 2'd0;
  localparam logic [1:0] REG_WINDOW  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  // Timer ticks per microsecond
  localparam int TICKS_PER_US = 6;

  // Distance scaling: hundredths of a cm = us * CM_SCALE / CM_DIVISOR
  localparam int CM_SCALE   = 100;
  localparam int CM_DIVISOR = 58;
  // Running distance needs room for the largest count before saturation
  localparam int DACC_W     = 19;
  localparam int DREM_W     = 6;

  // One result beat
  typedef struct packed {
    logic              trigger;
    logic              done_res;
    logic              no_target;
    logic [DIST_W-1:0] distance_hundredths;
  } res_t;

endpackage

[rtl/core/uer_in_if.sv]
// Tick input channel: start request and sampled echo level.
`timescale 1ns / 1ps

interface uer_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, output start_req, output echo, input ready);
  modport sink   (input valid, input start_req, input echo, output ready);
endinterface

[rtl/core/uer_out_if.sv]
// Result channel: trigger level, done flag, no-target flag and distance.
`timescale 1ns / 1ps

interface uer_out_if;
  logic                       valid;
  logic                       ready;
  logic                       trigger;
  logic                       done_res;
  logic                       no_target;
  logic [uer_pkg::DIST_W-1:0] distance_hundredths;

  modport source (output valid, output trigger, output done_res, output no_target,
                  output distance_hundredths, input ready);
  modport sink   (input valid, input trigger, input done_res, input no_target,
                  input distance_hundredths, output ready);
endinterface

[rtl/core/ultrasonic_echo_ranger.sv]
// Ultrasonic echo ranger: trigger sequencing, echo timing and distance output.
`timescale 1ns / 1ps

// Each input beat is one timer tick and yields exactly one result beat. A tick
// is taken every clock while the skid stage is empty: the state update and the
// result are one level of logic between the tick and the result register, and
// the sustained rate is one tick per clock unless the result side stalls. The
// distance is kept as a running value that steps with the echo count, so no
// divider or multiplier sits in the path. A one-beat skid stage behind the
// result register holds one tick while the result side stalls; filling it drops
// in_bus.ready. Registers over APB (pready always high): 0x0 trigger_ticks,
// 0x4 window_ticks, 0x8 timeout_ticks; a zero trigger or window length acts as
// one. Distance is floor(floor(count/TICKS_PER_US)*100/58) hundredths of a cm,
// saturated at 65535; a count above timeout_ticks reports no object.
module ultrasonic_echo_ranger #(
  parameter int TICKS_PER_US = uer_pkg::TICKS_PER_US
) (
  input  logic                       clk,
  input  logic                       rst_n,
  uer_in_if.sink                     in_bus,
  uer_out_if.source                  out_bus,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [uer_pkg::APB_AW-1:0] paddr,
  input  logic [uer_pkg::APB_DW-1:0] pwdata,
  output logic [uer_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  // Phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_TRIG   = 2'd1;
  localparam logic [1:0] PH_WAIT   = 2'd2;
  localparam logic [1:0] PH_LISTEN = 2'd3;

  localparam int TW = uer_pkg::TIMER_W;
  localparam int CW = uer_pkg::COUNT_W;
  localparam int AW = uer_pkg::DACC_W;
  localparam int RW = uer_pkg::DREM_W;
  localparam int DW = uer_pkg::APB_DW;

  // Tick remainder counter width: holds 0..TICKS_PER_US
  localparam int TREM_W = $clog2(TICKS_PER_US + 1);

  // Distance step per whole microsecond
  localparam int DSTEP = uer_pkg::CM_SCALE / uer_pkg::CM_DIVISOR;
  localparam int RSTEP = uer_pkg::CM_SCALE % uer_pkg::CM_DIVISOR;

  // Tracker state after the first echo tick (count of one)
  localparam logic [TREM_W-1:0] TREM_FIRST = (TICKS_PER_US == 1) ? TREM_W'(0) : TREM_W'(1);
  localparam logic [AW-1:0]     DACC_FIRST = (TICKS_PER_US == 1) ? AW'(DSTEP) : AW'(0);
  localparam logic [RW-1:0]     DREM_FIRST = (TICKS_PER_US == 1) ? RW'(RSTEP) : RW'(0);

  localparam logic [CW-1:0]     COUNT_MAX  = {CW{1'b1}};

  // Configuration registers
  logic [uer_pkg::TRIG_W-1:0]    trig_cfg_r;
  logic [uer_pkg::WIN_W-1:0]     win_cfg_r;
  logic [uer_pkg::TIMEOUT_W-1:0] timeout_cfg_r;

  // Ranging state
  logic [1:0]        phase_r, phase_nxt;
  logic [TW-1:0]     timer_r, timer_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              fall_r, fall_nxt;
  logic              echo_prev_r;
  logic [TREM_W-1:0] trem_r, trem_nxt;
  logic [AW-1:0]     dacc_r, dacc_nxt;
  logic [RW-1:0]     drem_r, drem_nxt;

  // Output register and skid stage
  uer_pkg::res_t res;
  uer_pkg::res_t out_r, skid_r;
  logic          out_valid_r, skid_valid_r;

  logic in_fire;
  logic out_open;

  // APB write and read
  wire cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_cfg_r    <= uer_pkg::TRIG_RST;
      win_cfg_r     <= uer_pkg::WIN_RST;
      timeout_cfg_r <= uer_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        uer_pkg::REG_TRIGGER: trig_cfg_r    <= pwdata[uer_pkg::TRIG_W-1:0];
        uer_pkg::REG_WINDOW:  win_cfg_r     <= pwdata[uer_pkg::WIN_W-1:0];
        uer_pkg::REG_TIMEOUT: timeout_cfg_r <= pwdata[uer_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      uer_pkg::REG_TRIGGER: prdata = DW'(trig_cfg_r);
      uer_pkg::REG_WINDOW:  prdata = DW'(win_cfg_r);
      uer_pkg::REG_TIMEOUT: prdata = DW'(timeout_cfg_r);
      default:              prdata = '0;
    endcase
  end

  // Effective lengths: zero acts as one
  wire [TW-1:0] trig_len = (trig_cfg_r == '0) ? TW'(1) : TW'(trig_cfg_r);
  wire [TW-1:0] win_len  = (win_cfg_r == '0) ? TW'(1) : TW'(win_cfg_r);

  // One step of the running distance (count grows by one)
  wire [TREM_W-1:0] trem_inc  = trem_r + TREM_W'(1);
  wire              us_wrap   = (trem_inc == TREM_W'(TICKS_PER_US));
  wire [RW:0]       drem_sum  = {1'b0, drem_r} + (RW+1)'(RSTEP);
  wire              drem_cy   = (drem_sum >= (RW+1)'(uer_pkg::CM_DIVISOR));
  wire [RW:0]       drem_red  = drem_sum - (RW+1)'(uer_pkg::CM_DIVISOR);

  wire [TREM_W-1:0] step_trem = us_wrap ? '0 : trem_inc;
  wire [AW-1:0]     step_dacc = !us_wrap ? dacc_r :
                                drem_cy ? dacc_r + AW'(DSTEP + 1) : dacc_r + AW'(DSTEP);
  wire [RW-1:0]     step_drem = !us_wrap ? drem_r :
                                drem_cy ? drem_red[RW-1:0] : drem_sum[RW-1:0];

  wire [uer_pkg::DIST_W-1:0] dist_sat =
    (dacc_r > AW'({uer_pkg::DIST_W{1'b1}})) ? {uer_pkg::DIST_W{1'b1}}
                                            : dacc_r[uer_pkg::DIST_W-1:0];

  wire [TW-1:0] timer_inc = timer_r + TW'(1);

  // Next state and result for one tick
  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    count_nxt = count_r;
    fall_nxt  = fall_r;
    trem_nxt  = trem_r;
    dacc_nxt  = dacc_r;
    drem_nxt  = drem_r;
    res       = '0;

    case (phase_r)
      PH_TRIG: begin
        if (timer_r >= trig_len) begin
          phase_nxt = PH_WAIT;
          timer_nxt = '0;
        end else begin
          timer_nxt   = timer_inc;
          res.trigger = 1'b1;
        end
      end
      PH_WAIT: begin
        // Echo rise opens the window and counts as the first echo tick
        if (in_bus.echo) begin
          phase_nxt = PH_LISTEN;
          timer_nxt = TW'(1);
          count_nxt = CW'(1);
          fall_nxt  = 1'b0;
          trem_nxt  = TREM_FIRST;
          dacc_nxt  = DACC_FIRST;
          drem_nxt  = DREM_FIRST;
          // A one-tick window closes on the rise itself and retriggers
          if (win_len == TW'(1)) begin
            phase_nxt   = PH_TRIG;
            res.trigger = 1'b1;
          end
        end
      end
      PH_LISTEN: begin
        timer_nxt = timer_inc;
        if (!fall_r) begin
          if (in_bus.echo) begin
            if (count_r != COUNT_MAX) begin
              count_nxt = count_r + CW'(1);
              trem_nxt  = step_trem;
              dacc_nxt  = step_dacc;
              drem_nxt  = step_drem;
            end
          end else if (echo_prev_r) begin
            fall_nxt = 1'b1;
          end
        end
        // Window end: report, or retrigger when the echo never fell
        if (timer_inc >= win_len) begin
          if (fall_nxt) begin
            res.done_res = 1'b1;
            if (count_r > timeout_cfg_r) res.no_target = 1'b1;
            else res.distance_hundredths = dist_sat;
            phase_nxt = PH_IDLE;
            timer_nxt = '0;
            count_nxt = '0;
            fall_nxt  = 1'b0;
          end else begin
            count_nxt   = '0;
            phase_nxt   = PH_TRIG;
            timer_nxt   = TW'(1);
            res.trigger = 1'b1;
          end
        end
      end
      default: begin
        if (in_bus.start_req) begin
          count_nxt   = '0;
          fall_nxt    = 1'b0;
          phase_nxt   = PH_TRIG;
          timer_nxt   = TW'(1);
          res.trigger = 1'b1;
        end
      end
    endcase
  end

  // Handshake: skid stage absorbs one beat while the output stalls
  assign in_bus.ready = !skid_valid_r;
  assign in_fire      = in_bus.valid && !skid_valid_r;
  assign out_open     = !out_valid_r || out_bus.ready;

  // State registers advance on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      timer_r     <= '0;
      count_r     <= '0;
      fall_r      <= 1'b0;
      echo_prev_r <= 1'b0;
      trem_r      <= '0;
      dacc_r      <= '0;
      drem_r      <= '0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      count_r     <= count_nxt;
      fall_r      <= fall_nxt;
      echo_prev_r <= in_bus.echo;
      trem_r      <= trem_nxt;
      dacc_r      <= dacc_nxt;
      drem_r      <= drem_nxt;
    end
  end

  // Result register and skid valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_open) begin
      out_valid_r  <= skid_valid_r || in_fire;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_open) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  assign out_bus.valid               = out_valid_r;
  assign out_bus.trigger             = out_r.trigger;
  assign out_bus.done_res            = out_r.done_res;
  assign out_bus.no_target           = out_r.no_target;
  assign out_bus.distance_hundredths = out_r.distance_hundredths;

endmodule

[verif/uer_range_check.sv]
// Result checker for the echo ranger: mirrors the ranging state and checks each result beat.
`timescale 1ns / 1ps

module uer_range_check (
  input  logic                       clk,
  input  logic                       rst_n,
  uer_in_if                          in_mon,
  uer_out_if                         out_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [uer_pkg::APB_AW-1:0] paddr,
  input  logic [uer_pkg::APB_DW-1:0] pwdata,
  output int                         fail_count,
  output int                         pending
);

  localparam int DIST_W  = uer_pkg::DIST_W;
  localparam int TIMER_W = uer_pkg::TIMER_W;
  localparam int COUNT_W = uer_pkg::COUNT_W;

  typedef enum logic [1:0] {
    RNG_IDLE,
    RNG_TRIG,
    RNG_WAIT,
    RNG_LISTEN
  } rng_phase_e;

  // Register copies, written from the APB port
  logic [uer_pkg::TRIG_W-1:0]    trig_reg;
  logic [uer_pkg::WIN_W-1:0]     win_reg;
  logic [uer_pkg::TIMEOUT_W-1:0] tmo_reg;

  // Mirrored ranging state
  rng_phase_e          rng_phase;
  logic [TIMER_W-1:0]  phase_tmr;
  logic [COUNT_W-1:0]  echo_cnt;
  logic                fall_seen;
  logic                echo_last;

  uer_pkg::res_t range_results[$];

  // Echo ticks to hundredths of a cm, saturated to the field width
  function automatic logic [DIST_W-1:0] hundredths_cm(logic [COUNT_W-1:0] cnt);
    int us;
    int d;
    us = int'(cnt) / uer_pkg::TICKS_PER_US;
    d  = us * uer_pkg::CM_SCALE / uer_pkg::CM_DIVISOR;
    if (d > 65535) d = 65535;
    return DIST_W'(d);
  endfunction

  // Advance the mirrored state by one tick and return the beat it produces
  function automatic uer_pkg::res_t step_ranger(logic start, logic echo);
    uer_pkg::res_t r;
    int   trig_n;
    int   win_n;
    r      = '0;
    trig_n = (trig_reg == 0) ? 1 : int'(trig_reg);
    win_n  = (win_reg == 0) ? 1 : int'(win_reg);
    case (rng_phase)
      RNG_TRIG: begin
        if (int'(phase_tmr) >= trig_n) begin
          rng_phase = RNG_WAIT;
          phase_tmr = '0;
        end else begin
          phase_tmr = phase_tmr + 1'b1;
          r.trigger = 1'b1;
        end
      end
      RNG_WAIT: begin
        // rise: first echo tick and first window tick
        if (echo) begin
          rng_phase = RNG_LISTEN;
          phase_tmr = TIMER_W'(1);
          echo_cnt  = COUNT_W'(1);
          fall_seen = 1'b0;
          if (int'(phase_tmr) >= win_n) begin
            rng_phase = RNG_TRIG;
            phase_tmr = TIMER_W'(1);
            r.trigger = 1'b1;
          end
        end
      end
      RNG_LISTEN: begin
        phase_tmr = phase_tmr + 1'b1;
        if (!fall_seen) begin
          if (echo) begin
            if (echo_cnt != {COUNT_W{1'b1}}) echo_cnt = echo_cnt + 1'b1;
          end else if (echo_last) begin
            fall_seen = 1'b1;
          end
        end
        if (int'(phase_tmr) >= win_n) begin
          if (fall_seen) begin
            r.done_res = 1'b1;
            if (echo_cnt > tmo_reg) r.no_target = 1'b1;
            else r.distance_hundredths = hundredths_cm(echo_cnt);
            rng_phase = RNG_IDLE;
            phase_tmr = '0;
            echo_cnt  = '0;
            fall_seen = 1'b0;
          end else begin
            // echo still high at window end: retry with a fresh count
            echo_cnt  = '0;
            rng_phase = RNG_TRIG;
            phase_tmr = TIMER_W'(1);
            r.trigger = 1'b1;
          end
        end
      end
      default: begin
        rng_phase = RNG_IDLE;
        if (start) begin
          echo_cnt  = '0;
          fall_seen = 1'b0;
          rng_phase = RNG_TRIG;
          phase_tmr = TIMER_W'(1);
          r.trigger = 1'b1;
        end
      end
    endcase
    echo_last = echo;
    return r;
  endfunction

  function automatic void field_chk(string nm, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // Track register writes, predict on each tick beat, compare each result beat
  always @(posedge clk) begin
    uer_pkg::res_t exp_r;
    if (!rst_n) begin
      trig_reg   = uer_pkg::TRIG_RST;
      win_reg    = uer_pkg::WIN_RST;
      tmo_reg    = uer_pkg::TIMEOUT_RST;
      rng_phase  = RNG_IDLE;
      phase_tmr  = '0;
      echo_cnt   = '0;
      fall_seen  = 1'b0;
      echo_last  = 1'b0;
      fail_count = 0;
      range_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          uer_pkg::REG_TRIGGER: trig_reg = pwdata[uer_pkg::TRIG_W-1:0];
          uer_pkg::REG_WINDOW:  win_reg  = pwdata[uer_pkg::WIN_W-1:0];
          uer_pkg::REG_TIMEOUT: tmo_reg  = pwdata[uer_pkg::TIMEOUT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        range_results.push_back(step_ranger(in_mon.start_req, in_mon.echo));
      if (out_mon.valid && out_mon.ready) begin
        if (range_results.size() == 0) begin
          $display({"%0t: unexpected result beat, expected none, ",
                    "got trig=%0b done=%0b ntgt=%0b dist=%0d"},
                   $time, out_mon.trigger, out_mon.done_res, out_mon.no_target,
                   out_mon.distance_hundredths);
          fail_count++;
        end else begin
          exp_r = range_results.pop_front();
          field_chk("trigger", exp_r.trigger, out_mon.trigger);
          field_chk("done_res", exp_r.done_res, out_mon.done_res);
          field_chk("no_target", exp_r.no_target, out_mon.no_target);
          field_chk("distance_hundredths", exp_r.distance_hundredths,
                    out_mon.distance_hundredths);
        end
      end
    end
    pending = range_results.size();
  end

endmodule

[verif/tb_top.sv]
// Testbench top for the echo ranger: clock, reset, tick stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int ITEM_TARGET = 1750;
  localparam int SETTLE_CYC  = 8;
  localparam int HOLD_CYC    = 120;
  localparam int DW          = uer_pkg::APB_DW;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                       psel, penable, pwrite, pready;
  logic [uer_pkg::APB_AW-1:0] paddr;
  logic [DW-1:0]              pwdata;
  logic [DW-1:0]              prdata;

  int  fail_count;
  int  pending;
  int  cycle_cnt = 0;
  int  sent_ticks = 0;
  int  cfg_trig, cfg_win, cfg_tmo;
  bit  hold_req = 1'b0;
  bit  tx_calm = 1'b0;

  uer_in_if  in_bus ();
  uer_out_if out_bus ();

  ultrasonic_echo_ranger dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  uer_range_check u_range_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stalls, calm stretches, and one long hold-off on request
  initial begin
    int stall_left;
    int hold_left;
    bit rx_calm;
    stall_left = 0;
    hold_left  = 0;
    rx_calm    = 1'b0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYC;
        hold_req  = 1'b0;
      end
      if ($urandom_range(0, 299) == 0) rx_calm = ~rx_calm;
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 99) < 92) ? $urandom_range(0, 2)
                                                   : $urandom_range(8, 25);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  function automatic int len_of(int v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int tx_gap();
    int r;
    if ($urandom_range(0, 299) == 0) tx_calm = ~tx_calm;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // One tick beat; entered and left at a falling edge
  task automatic send_tick(input bit s, input bit e);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.start_req <= s;
    in_bus.echo      <= e;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    sent_ticks++;
    @(negedge clk);
  endtask

  // busy: start may toggle (block ignores it); scramble: echo random
  task automatic ticks(input int n, input bit busy, input bit echo_lvl, input bit scramble);
    for (int i = 0; i < n; i++)
      send_tick(busy ? 1'($urandom) : 1'b0, scramble ? 1'($urandom) : echo_lvl);
  endtask

  // S start, T start with echo high, 1 echo high, anything else idle low
  task automatic play(input string pat);
    for (int i = 0; i < pat.len(); i++) begin
      case (pat[i])
        "S":     send_tick(1'b1, 1'b0);
        "T":     send_tick(1'b1, 1'b1);
        "1":     send_tick(1'b0, 1'b1);
        default: send_tick(1'b0, 1'b0);
      endcase
    end
  endtask

  // Stop offering until every predicted beat has come back
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= DW'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input int t, input int w, input int m);
    drain();
    write_reg(uer_pkg::REG_TRIGGER, t);
    write_reg(uer_pkg::REG_WINDOW, w);
    write_reg(uer_pkg::REG_TIMEOUT, m);
    cfg_trig = t;
    cfg_win  = w;
    cfg_tmo  = m;
  endtask

  // Bring the block back to idle from any phase (window of two or more)
  task automatic settle();
    int n;
    n = ((len_of(cfg_trig) > len_of(cfg_win)) ? len_of(cfg_trig) : len_of(cfg_win)) + 2;
    ticks(n, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    ticks(len_of(cfg_win) + 2, 1'b0, 1'b0, 1'b0);
  endtask

  // Full measurement from idle, optionally with one retry before the good echo
  task automatic measure(input bit retry);
    int trig_n, win_n, wait_n, high_n;
    trig_n = len_of(cfg_trig);
    win_n  = len_of(cfg_win);
    wait_n = $urandom_range(0, 4);
    send_tick(1'b1, 1'b0);
    ticks(trig_n, 1'b1, 1'b0, 1'b1);
    ticks(wait_n, 1'b1, 1'b0, 1'b0);
    if (retry) begin
      // echo held through the whole window, then a fresh trigger
      wait_n = $urandom_range(0, 4);
      ticks(win_n, 1'b1, 1'b1, 1'b0);
      ticks(trig_n, 1'b1, 1'b0, 1'b1);
      ticks(wait_n, 1'b1, 1'b0, 1'b0);
    end
    high_n = $urandom_range(1, win_n - 1);
    // aim at the timeout boundary now and then
    if ($urandom_range(0, 99) < 30) begin
      high_n = cfg_tmo + $urandom_range(0, 1);
      if (high_n > win_n - 1) high_n = win_n - 1;
    end
    ticks(high_n, 1'b1, 1'b1, 1'b0);
    ticks(win_n - high_n, 1'b1, 1'b0, 1'b0);
    ticks($urandom_range(0, 2), 1'b0, 1'b0, 1'b1);
  endtask

  // Stimulus
  initial begin
    int seq_n;
    int w;
    int pick;
    in_bus.valid     = 1'b0;
    in_bus.start_req = 1'b0;
    in_bus.echo      = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    cfg_trig = 90000;
    cfg_win  = 300000;
    cfg_tmo  = 180000;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: idle ticks at reset values
    play("0110");
    // zero trigger length, timeout of one: distance, no target, busy start, retry
    set_config(0, 3, 1);
    play("S0100");
    play("S0T10");
    play("S0111S0100");
    // zero window: the rise itself ends the window and retriggers
    set_config(1, 0, 1);
    play("S010");

    // Register extremes; block sits waiting with echo low
    set_config(1048575, 4194303, 262143);
    ticks(16, 1'b1, 1'b0, 1'b0);
    set_config(3, 12, 5);
    settle();

    // Random part
    seq_n = 0;
    while (sent_ticks < ITEM_TARGET) begin
      if (seq_n % 8 == 0) begin
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(2, 24);
        set_config($urandom_range(0, 6), w,
                   ($urandom_range(0, 9) == 0) ? 262143 : $urandom_range(1, w + 1));
      end
      // long result hold-off while ticks keep coming
      if (seq_n == 3) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        measure(1'b0);
      end else if (pick < 85) begin
        measure(1'b1);
      end else begin
        for (int i = $urandom_range(5, 30); i > 0; i--)
          send_tick(1'($urandom), 1'($urandom));
        settle();
      end
      seq_n++;
    end

    drain();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
